### sv/pfa_pkg.sv
package pfa_pkg;

    localparam int ROOM_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 4'd1;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    typedef struct packed {
        logic               fit_mode;
        logic [COUNT_W-1:0] part_count;
    } t_cfg;

endpackage

### sv/pfa_room_mem.sv
module pfa_room_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [pfa_pkg::ROOM_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [pfa_pkg::ROOM_W-1:0] i_wr_data
);

    logic [pfa_pkg::ROOM_W-1:0] r_mem [DEPTH];
    logic [pfa_pkg::ROOM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/pfa_ctrl.sv
module pfa_ctrl #(
    parameter int PARTITIONS = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfa_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [pfa_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pfa_pkg::ROOM_W-1:0]  i_amount,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_granted,
    output logic [pfa_pkg::SLOT_W-1:0]  o_block_index,
    output logic                        o_rd_en,
    output logic [IDX_W-1:0]            o_rd_addr,
    input  logic [pfa_pkg::ROOM_W-1:0]  i_rd_data,
    output logic                        o_wr_en,
    output logic [IDX_W-1:0]            o_wr_addr,
    output logic [pfa_pkg::ROOM_W-1:0]  o_wr_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [pfa_pkg::ROOM_W-1:0]  r_amount, n_amount;
    logic                        r_mode, n_mode;
    logic [CNT_W-1:0]            r_limit, n_limit;
    logic [CNT_W-1:0]            r_idx, n_idx;
    logic                        r_dv, n_dv;
    logic [IDX_W-1:0]            r_dv_idx, n_dv_idx;
    logic                        r_found, n_found;
    logic [IDX_W-1:0]            r_pick, n_pick;
    logic [pfa_pkg::ROOM_W-1:0]  r_best, n_best;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_granted, n_out_granted;
    logic [pfa_pkg::SLOT_W-1:0]  r_out_index, n_out_index;

    logic in_acc;
    logic out_acc;
    logic hit;
    logic take;
    logic found_now;
    logic issue;
    logic [CNT_W-1:0] cfg_limit;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    assign hit       = (r_state == ST_SCAN) && r_dv && (i_rd_data >= r_amount);
    assign take      = hit && (!r_found || (i_rd_data < r_best));
    assign found_now = r_found || hit;
    assign issue     = (r_state == ST_SCAN) && (r_idx < r_limit)
                       && !((r_mode == pfa_pkg::FIT_FIRST) && found_now);

    always_comb begin
        if (32'(i_cfg.part_count) > PARTITIONS) begin
            cfg_limit = CNT_W'(PARTITIONS);
        end else begin
            cfg_limit = CNT_W'(i_cfg.part_count);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_amount      = r_amount;
        n_mode        = r_mode;
        n_limit       = r_limit;
        n_idx         = r_idx;
        n_dv          = 1'b0;
        n_dv_idx      = r_dv_idx;
        n_found       = r_found;
        n_pick        = r_pick;
        n_best        = r_best;
        n_out_valid   = r_out_valid && !out_acc;
        n_out_granted = r_out_granted;
        n_out_index   = r_out_index;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_pick;
        o_wr_data     = r_best - r_amount;
        o_rd_en       = issue;
        o_rd_addr     = r_idx[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_action == pfa_pkg::ACT_LOAD) begin
                        if (32'(i_slot) < PARTITIONS) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = IDX_W'(i_slot);
                            o_wr_data = i_amount;
                        end
                    end else begin
                        n_state  = ST_SCAN;
                        n_amount = i_amount;
                        n_mode   = i_cfg.fit_mode;
                        n_limit  = cfg_limit;
                        n_idx    = '0;
                        n_found  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (take) begin
                    n_found = 1'b1;
                    n_pick  = r_dv_idx;
                    n_best  = i_rd_data;
                end
                if (issue) begin
                    n_dv     = 1'b1;
                    n_dv_idx = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + CNT_W'(1);
                end else if (found_now) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_WRITE: begin
                o_wr_en = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || out_acc) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_found;
                    n_out_index   = r_found ? pfa_pkg::SLOT_W'(r_pick) : '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amount      <= n_amount;
        r_mode        <= n_mode;
        r_limit       <= n_limit;
        r_idx         <= n_idx;
        r_dv_idx      <= n_dv_idx;
        r_pick        <= n_pick;
        r_best        <= n_best;
        r_out_granted <= n_out_granted;
        r_out_index   <= n_out_index;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_out_granted;
    assign o_block_index = r_out_index;

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_state == ST_SCAN) && (r_idx < r_limit))
        else $error("read issued outside the search range");

    a_write_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> r_found)
        else $error("writeback without a chosen partition");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_granted) |-> (r_out_index == '0))
        else $error("refused transaction carries a nonzero index");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid && $stable(r_out_index))
        else $error("stalled result dropped or changed");

endmodule

### sv/partition_fit_allocator.sv
// load transaction: written to the room memory in the cycle it is accepted, no result
// allocate: memory scan, writeback if a partition is chosen, then result registered
// input stalls until an allocate is done; the scan issues one memory read a cycle
// the next transaction is accepted while a finished result waits on the output register
// reset (synchronous, active low): idle, output empty, first fit, 16 partitions searched
module partition_fit_allocator #(
    parameter int PARTITIONS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfa_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [pfa_pkg::SLOT_W-1:0]     i_slot,
    input  logic [pfa_pkg::ROOM_W-1:0]     i_amount,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_granted,
    output logic [pfa_pkg::SLOT_W-1:0]     o_block_index
);

    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W = $clog2(PARTITIONS + 1);

    pfa_pkg::t_cfg r_cfg;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [pfa_pkg::ROOM_W-1:0] rd_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [pfa_pkg::ROOM_W-1:0] wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_mode   <= pfa_pkg::FIT_FIRST;
            r_cfg.part_count <= pfa_pkg::COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfa_pkg::CFG_FIT_MODE:   r_cfg.fit_mode   <= i_cfg_data[0];
                pfa_pkg::CFG_PART_COUNT: r_cfg.part_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pfa_ctrl #(
        .PARTITIONS (PARTITIONS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_granted     (o_granted),
        .o_block_index (o_block_index),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    pfa_room_mem #(
        .DEPTH  (PARTITIONS),
        .ADDR_W (IDX_W)
    ) u_room_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PARTS          = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    // register index past the end of the list
    localparam logic [pfa_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 4'd9;

    typedef struct packed {
        logic                       granted;
        logic [pfa_pkg::SLOT_W-1:0] block_index;
    } t_alloc_grant;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pfa_pkg::COUNT_W-1:0]   i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    logic [pfa_pkg::SLOT_W-1:0]    i_slot;
    logic [pfa_pkg::ROOM_W-1:0]    i_amount;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_granted;
    logic [pfa_pkg::SLOT_W-1:0]    o_block_index;

    // predicted allocator state
    logic [pfa_pkg::ROOM_W-1:0]  room_tbl [PARTS];
    logic                        fit_sel;
    logic [pfa_pkg::COUNT_W-1:0] part_cnt;
    t_alloc_grant                grant_q[$];

    bit quiet;
    int mismatches;
    int good_cnt;
    int n_alloc;
    int n_grant;
    int n_load;
    int n_cfg;
    int stuck;

    partition_fit_allocator #(.PARTITIONS(PARTS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_granted     (o_granted),
        .o_block_index (o_block_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_alloc_grant predict_alloc(input logic [pfa_pkg::ROOM_W-1:0] amt);
        t_alloc_grant r;
        int lim;
        int j;
        int pick;
        bit hit;
        lim = (part_cnt > PARTS) ? PARTS : int'(part_cnt);
        hit = 1'b0;
        pick = 0;
        for (j = 0; j < lim; j++) begin
            if (room_tbl[j] >= amt) begin
                if (!hit) begin
                    hit = 1'b1;
                    pick = j;
                    if (fit_sel == pfa_pkg::FIT_FIRST) break;
                end else if (room_tbl[j] < room_tbl[pick]) begin
                    pick = j;
                end
            end
        end
        if (hit) room_tbl[pick] = room_tbl[pick] - amt;
        r.granted = hit;
        r.block_index = hit ? pfa_pkg::SLOT_W'(pick) : '0;
        return r;
    endfunction

    function automatic logic [pfa_pkg::ROOM_W-1:0] rand_room();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return pfa_pkg::ROOM_W'($urandom_range(0, 255));
            3: return pfa_pkg::ROOM_W'(100 * $urandom_range(1, 4));
            default: return pfa_pkg::ROOM_W'($urandom);
        endcase
    endfunction

    function automatic logic [pfa_pkg::ROOM_W-1:0] rand_request();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return room_tbl[$urandom_range(0, PARTS - 1)];
            2: return room_tbl[$urandom_range(0, PARTS - 1)] + 1'b1;
            3: return pfa_pkg::ROOM_W'($urandom_range(1, 64));
            4: return pfa_pkg::ROOM_W'($urandom_range(1, 1024));
            5: return pfa_pkg::ROOM_W'(100);
            default: return pfa_pkg::ROOM_W'($urandom);
        endcase
    endfunction

    // transaction monitor and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_action == pfa_pkg::ACT_LOAD) begin
                room_tbl[i_slot] = i_amount;
                n_load++;
            end else begin
                grant_q.push_back(predict_alloc(i_amount));
                n_alloc++;
                if (grant_q[$].granted) n_grant++;
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            n_cfg++;
            case (i_cfg_index)
                pfa_pkg::CFG_FIT_MODE:   fit_sel = i_cfg_data[0];
                pfa_pkg::CFG_PART_COUNT: part_cnt = i_cfg_data;
                default: ;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_alloc_grant want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: granted=%0b index=%0d",
                             $realtime, o_granted, o_block_index);
            end else begin
                want = grant_q.pop_front();
                if (o_granted !== want.granted || o_block_index !== want.block_index) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: mismatch: expected granted=%0b index=%0d, ",
                                  "got granted=%0b index=%0d"},
                                 $realtime, want.granted, want.block_index,
                                 o_granted, o_block_index);
                end else begin
                    good_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results still pending", $realtime, grant_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side stall bursts
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) @(negedge i_clk);
            if (!quiet) begin
                i_out_stall = 1'b1;
                n = $urandom_range(1, 15);
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(input logic act, input logic [pfa_pkg::SLOT_W-1:0] slot,
                             input logic [pfa_pkg::ROOM_W-1:0] amt);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action = act;
        i_slot = slot;
        i_amount = amt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic cfg_write(input logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfa_pkg::COUNT_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for every pending result to be taken, then let the design idle
    task automatic settle();
        while (grant_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_first_fit();
        cfg_write(pfa_pkg::CFG_FIT_MODE, 5'b11110);
        cfg_write(pfa_pkg::CFG_PART_COUNT, 5'd4);
        cfg_write(CFG_NO_REG, 5'd3);
        send_item(pfa_pkg::ACT_LOAD, 4'd0, 16'd0);
        send_item(pfa_pkg::ACT_LOAD, 4'd1, 16'hFFFF);
        send_item(pfa_pkg::ACT_LOAD, 4'd2, 16'd100);
        send_item(pfa_pkg::ACT_LOAD, 4'd3, 16'd100);
        send_item(pfa_pkg::ACT_ALLOC, 4'd15, 16'd0);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'hFFFF);
        send_item(pfa_pkg::ACT_ALLOC, 4'd5, 16'd101);
    endtask

    task automatic test_best_fit();
        send_item(pfa_pkg::ACT_LOAD, 4'd9, 16'd500);
        send_item(pfa_pkg::ACT_LOAD, 4'd1, 16'd300);
        settle();
        cfg_write(pfa_pkg::CFG_FIT_MODE, {4'b0000, pfa_pkg::FIT_BEST});
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd50);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd60);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd0);
    endtask

    task automatic test_count_limits();
        int j;
        settle();
        cfg_write(pfa_pkg::CFG_PART_COUNT, 5'd0);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd0);
        for (j = 4; j < PARTS; j++)
            if (j != 9) send_item(pfa_pkg::ACT_LOAD, pfa_pkg::SLOT_W'(j),
                                  pfa_pkg::ROOM_W'(1000 + 37 * j));
        settle();
        cfg_write(pfa_pkg::CFG_PART_COUNT, 5'd31);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd400);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'hFFFF);
        settle();
        cfg_write(pfa_pkg::CFG_PART_COUNT, 5'd1);
        send_item(pfa_pkg::ACT_ALLOC, 4'd0, 16'd0);
    endtask

    task automatic run_phase(input logic fm, input logic [pfa_pkg::COUNT_W-1:0] cnt,
                             input int n_items);
        int k;
        settle();
        cfg_write(pfa_pkg::CFG_FIT_MODE, {4'b0000, fm});
        cfg_write(pfa_pkg::CFG_PART_COUNT, cnt);
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) < 3)
                send_item(pfa_pkg::ACT_LOAD, pfa_pkg::SLOT_W'($urandom_range(0, PARTS - 1)),
                          rand_room());
            else
                send_item(pfa_pkg::ACT_ALLOC, pfa_pkg::SLOT_W'($urandom), rand_request());
        end
    endtask

    task automatic test_random_traffic();
        run_phase(pfa_pkg::FIT_FIRST, 5'd16, 400);
        run_phase(pfa_pkg::FIT_BEST, 5'd16, 400);
        run_phase(pfa_pkg::FIT_FIRST, 5'd7, 250);
        run_phase(pfa_pkg::FIT_BEST, 5'd1, 150);
        run_phase(pfa_pkg::FIT_BEST, 5'd31, 250);
        run_phase(pfa_pkg::FIT_FIRST, 5'd0, 50);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        run_phase(pfa_pkg::FIT_BEST, 5'd12, 400);
    endtask

    initial begin
        quiet = 1'b0;
        mismatches = 0;
        good_cnt = 0;
        n_alloc = 0;
        n_grant = 0;
        n_load = 0;
        n_cfg = 0;
        stuck = 0;
        fit_sel = pfa_pkg::FIT_FIRST;
        part_cnt = pfa_pkg::COUNT_RESET;
        foreach (room_tbl[j]) room_tbl[j] = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_action = pfa_pkg::ACT_LOAD;
        i_slot = '0;
        i_amount = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_fit();
        test_best_fit();
        test_count_limits();
        test_random_traffic();
        test_back_to_back();
        settle();

        $display("ran %0d allocations (%0d granted, %0d checked ok), %0d loads, %0d reg writes",
                 n_alloc, n_grant, good_cnt, n_load, n_cfg);
        $display("first and best fit, counts 0/1/4/7/12/16/31, idling on both sides then none");
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, grant_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
